[hw/rtl/multi_lane_priority_queue_unit_defines.svh]
// assertion macros for the multi-lane priority queue
`ifndef MULTI_LANE_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MULTI_LANE_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// clocked property, off while reset is asserted
`define MLPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be true
`define MLPQ_ASSERT_NEVER(name, cond, msg) \
  `MLPQ_ASSERT(name, !(cond), msg)

`endif

[hw/rtl/mlpq_pkg.sv]
// shared types and constants of the multi-lane priority queue
package mlpq_pkg;

  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 104;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned TOT_W   = 32;

  localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 7'd10;
  localparam logic [TOT_W-1:0]   TOT_MAX          = 32'hFFFF_FFFF;

  // command codes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LANE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // density classes
  localparam logic [1:0] DENS_LOW    = 2'd0;
  localparam logic [1:0] DENS_MEDIUM = 2'd1;
  localparam logic [1:0] DENS_HIGH   = 2'd2;

  // input transaction, last field in the lowest bits
  typedef struct packed {
    logic [1:0]  pad;
    logic        urgent;
    logic [15:0] entry_id;
    logic [2:0]  lane;
    logic [1:0]  mode;
  } in_item_t;

  // result transaction, last field in the lowest bits
  typedef struct packed {
    logic [2:0]       pad;
    logic [8:0]       total_waiting;
    logic [TOT_W-1:0] total_removed;
    logic [TOT_W-1:0] total_added;
    logic [1:0]       density;
    logic [6:0]       lane_occupancy;
    logic             removed_urgent;
    logic [15:0]      removed_id;
    logic [1:0]       status;
  } out_item_t;

  // lane table update request
  typedef struct packed {
    logic clear;
    logic add;
    logic remove;
  } upd_t;

endpackage

[hw/rtl/mlpq_entry_mem.sv]
// shared entry store, one write and one registered read per cycle
module mlpq_entry_mem #(
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 17
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mlpq_lane_table.sv]
// per-lane head and fill pointers plus the global counters
module mlpq_lane_table #(
  parameter int unsigned NUM_LANES   = 4,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mlpq_pkg::upd_t                    upd_i,
  input  logic [$clog2(NUM_LANES)-1:0]      lane_i,
  output logic [$clog2(QUEUE_DEPTH)-1:0]    head_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  used_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  occ_next_o,
  output logic [mlpq_pkg::TOT_W-1:0]        added_next_o,
  output logic [mlpq_pkg::TOT_W-1:0]        removed_next_o,
  output logic [$clog2(NUM_LANES*QUEUE_DEPTH+1)-1:0] waiting_next_o
);

  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WAIT_W = $clog2(NUM_LANES * QUEUE_DEPTH + 1);

  logic [SLOT_W-1:0]          head_q [NUM_LANES];
  logic [CNT_W-1:0]           used_q [NUM_LANES];
  logic [mlpq_pkg::TOT_W-1:0] added_q, removed_q;
  logic [WAIT_W-1:0]          waiting_q;

  logic [SLOT_W-1:0]          head_d;
  logic [CNT_W-1:0]           used_d, occ_cur, occ_d;
  logic [mlpq_pkg::TOT_W-1:0] added_d, removed_d;
  logic [WAIT_W-1:0]          waiting_d;

  assign head_o  = head_q[lane_i];
  assign used_o  = used_q[lane_i];
  assign occ_cur = used_q[lane_i] - CNT_W'(head_q[lane_i]);

  always_comb begin
    head_d    = head_q[lane_i];
    used_d    = used_q[lane_i];
    occ_d     = occ_cur;
    added_d   = added_q;
    removed_d = removed_q;
    waiting_d = waiting_q;
    if (upd_i.clear) begin
      head_d    = '0;
      used_d    = '0;
      occ_d     = '0;
      added_d   = '0;
      removed_d = '0;
      waiting_d = '0;
    end else if (upd_i.add) begin
      used_d    = used_q[lane_i] + CNT_W'(1);
      occ_d     = occ_cur + CNT_W'(1);
      waiting_d = waiting_q + WAIT_W'(1);
      if (added_q != mlpq_pkg::TOT_MAX) begin
        added_d = added_q + mlpq_pkg::TOT_W'(1);
      end
    end else if (upd_i.remove) begin
      occ_d     = occ_cur - CNT_W'(1);
      waiting_d = waiting_q - WAIT_W'(1);
      if (removed_q != mlpq_pkg::TOT_MAX) begin
        removed_d = removed_q + mlpq_pkg::TOT_W'(1);
      end
      // an emptied lane starts over at slot zero
      if (occ_d == '0) begin
        head_d = '0;
        used_d = '0;
      end else begin
        head_d = head_q[lane_i] + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        head_q[i] <= '0;
        used_q[i] <= '0;
      end
      added_q   <= '0;
      removed_q <= '0;
      waiting_q <= '0;
    end else begin
      if (upd_i.clear) begin
        for (int i = 0; i < NUM_LANES; i++) begin
          head_q[i] <= '0;
          used_q[i] <= '0;
        end
      end else if (upd_i.add || upd_i.remove) begin
        head_q[lane_i] <= head_d;
        used_q[lane_i] <= used_d;
      end
      added_q   <= added_d;
      removed_q <= removed_d;
      waiting_q <= waiting_d;
    end
  end

  assign occ_next_o     = occ_d;
  assign added_next_o   = added_d;
  assign removed_next_o = removed_d;
  assign waiting_next_o = waiting_d;

endmodule

[hw/rtl/multi_lane_priority_queue_unit.sv]
// multi-lane priority queue: lanes of entries in one shared store, command sequencer
// sequence: query, clear, failed commands and plain adds finish in S_EXEC; a successful remove
//   reads the head entry in S_EXEC and finishes in S_READ (one registered store read)
// urgent add to a non-empty lane goes S_EXEC, S_SHIFT, S_INSERT: the store has one write port,
//   so the entries from the head on move up one slot per cycle
// throughput: one command at a time, the next is accepted once the result is registered
// reset: all lanes empty, counters zero, medium limit 10; the entry store is not cleared
`include "multi_lane_priority_queue_unit_defines.svh"

module multi_lane_priority_queue_unit #(
  parameter int unsigned NUM_LANES   = 4,
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // medium limit register write
  input  logic                          cfg_we_i,
  input  logic [mlpq_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  // commands: mode[1:0], lane[4:2], entry_id[20:5], urgent[21], zero pad[23:22]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mlpq_pkg::IN_W-1:0]     s_axis_tdata,
  // results: status[1:0], removed_id[17:2], removed_urgent[18], lane_occupancy[25:19],
  // density[27:26], total_added[59:28], total_removed[91:60], total_waiting[100:92],
  // zero pad[103:101]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mlpq_pkg::OUT_W-1:0]    m_axis_tdata
);

  localparam int unsigned LANE_W = $clog2(NUM_LANES);
  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WAIT_W = $clog2(NUM_LANES * QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W = LANE_W + SLOT_W;
  localparam int unsigned DATA_W = ID_BITS + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;  // decide, finish simple commands
  localparam logic [2:0] S_READ   = 3'd2;  // head entry read back for a remove
  localparam logic [2:0] S_SHIFT  = 3'd3;  // move entries up one slot for urgent add
  localparam logic [2:0] S_INSERT = 3'd4;  // write the urgent entry at the head

  mlpq_pkg::in_item_t  in_item;
  mlpq_pkg::out_item_t res;

  logic [2:0]                   state_q, state_d;
  logic [1:0]                   mode_q;
  logic [LANE_W-1:0]            lane_q;
  logic                         lane_ok_q, lane_ok;
  logic [ID_BITS-1:0]           id_q;
  logic                         urg_q;
  logic [SLOT_W-1:0]            idx_q, idx_d;
  logic [mlpq_pkg::LIMIT_W-1:0] limit_q;

  logic                         out_valid_q;
  mlpq_pkg::out_item_t          out_data_q;

  logic                         accept, out_free, fin;
  mlpq_pkg::upd_t               upd;

  // lane table view
  logic [SLOT_W-1:0]            cur_head;
  logic [CNT_W-1:0]             cur_used, cur_occ, occ_next;
  logic [mlpq_pkg::TOT_W-1:0]   added_next, removed_next;
  logic [WAIT_W-1:0]            waiting_next;

  // entry store port
  logic                         mem_we, mem_re;
  logic [ADDR_W-1:0]            mem_waddr, mem_raddr;
  logic [DATA_W-1:0]            mem_wdata, mem_rdata;

  // command decode
  logic is_clear, is_add, is_rem, lane_full, lane_empty;
  logic [1:0] status;

  assign in_item       = mlpq_pkg::in_item_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign lane_ok       = (4'(in_item.lane) < 4'(NUM_LANES));

  // command capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= in_item.mode;
      lane_q    <= lane_ok ? in_item.lane[LANE_W-1:0] : '0;
      lane_ok_q <= lane_ok;
      id_q      <= ID_BITS'(in_item.entry_id);
      urg_q     <= in_item.urgent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mlpq_pkg::MEDIUM_LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  mlpq_lane_table #(
    .NUM_LANES   (NUM_LANES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_lane_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (upd),
    .lane_i         (lane_q),
    .head_o         (cur_head),
    .used_o         (cur_used),
    .occ_next_o     (occ_next),
    .added_next_o   (added_next),
    .removed_next_o (removed_next),
    .waiting_next_o (waiting_next)
  );

  mlpq_entry_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cur_occ    = cur_used - CNT_W'(cur_head);
  assign is_clear   = (mode_q == mlpq_pkg::MODE_CLEAR);
  assign is_add     = (mode_q == mlpq_pkg::MODE_ADD) && lane_ok_q;
  assign is_rem     = (mode_q == mlpq_pkg::MODE_REMOVE) && lane_ok_q;
  assign lane_full  = (32'(cur_used) >= 32'(QUEUE_DEPTH));
  assign lane_empty = (cur_occ == '0);

  // lane table stays untouched until the finishing cycle, so this holds in every state
  always_comb begin
    if (is_clear) begin
      status = mlpq_pkg::ST_OK;
    end else if (!lane_ok_q) begin
      status = mlpq_pkg::ST_BAD_LANE;
    end else if (is_add && lane_full) begin
      status = mlpq_pkg::ST_FULL;
    end else if (is_rem && lane_empty) begin
      status = mlpq_pkg::ST_EMPTY;
    end else begin
      status = mlpq_pkg::ST_OK;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    upd       = '0;
    fin       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = {lane_q, cur_head};
    mem_wdata = {1'b1, id_q};
    mem_re    = 1'b0;
    mem_raddr = {lane_q, cur_head};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_add && !lane_full && urg_q && !lane_empty) begin
          // start moving the tail up: read the last entry
          mem_re    = 1'b1;
          mem_raddr = {lane_q, cur_used[SLOT_W-1:0] - SLOT_W'(1)};
          idx_d     = cur_used[SLOT_W-1:0];
          state_d   = S_SHIFT;
        end else if (is_rem && !lane_empty) begin
          mem_re  = 1'b1;
          state_d = S_READ;
        end else if (out_free) begin
          fin     = 1'b1;
          state_d = S_IDLE;
          if (is_clear) begin
            upd.clear = 1'b1;
          end else if (is_add && !lane_full) begin
            // urgent entry into an empty lane lands on the head slot, same as the tail
            mem_we    = 1'b1;
            mem_waddr = {lane_q, cur_used[SLOT_W-1:0]};
            mem_wdata = {urg_q, id_q};
            upd.add   = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = {lane_q, idx_q};
        mem_wdata = mem_rdata;
        if ((idx_q - SLOT_W'(1)) == cur_head) begin
          state_d = S_INSERT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = {lane_q, idx_q - SLOT_W'(2)};
          idx_d     = idx_q - SLOT_W'(1);
        end
      end
      S_INSERT: begin
        if (out_free) begin
          mem_we  = 1'b1;
          upd.add = 1'b1;
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          upd.remove = 1'b1;
          fin        = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // result assembly from the post-command lane view
  always_comb begin
    res                = '0;
    res.status         = status;
    res.total_added    = added_next;
    res.total_removed  = removed_next;
    res.total_waiting  = 9'(waiting_next);
    if (state_q == S_READ) begin
      res.removed_id     = 16'(mem_rdata[ID_BITS-1:0]);
      res.removed_urgent = mem_rdata[ID_BITS];
    end
    if (!is_clear && lane_ok_q) begin
      res.lane_occupancy = 7'(occ_next);
      if (occ_next == '0) begin
        res.density = mlpq_pkg::DENS_LOW;
      end else if (32'(occ_next) <= 32'(limit_q)) begin
        res.density = mlpq_pkg::DENS_MEDIUM;
      end else begin
        res.density = mlpq_pkg::DENS_HIGH;
      end
    end
  end

  // output register parts the result from the command side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_data_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // one command in work at a time
  `MLPQ_ASSERT(a_one_in_work, accept |=> !s_axis_tready, "command accepted while one is in work")
  // the move never reaches below the head slot
  `MLPQ_ASSERT(a_shift_above_head, (state_q == S_SHIFT) |-> (idx_q > cur_head),
               "entry move went past the lane head")
  // a result appears only from a finishing state
  `MLPQ_ASSERT(a_result_source, $rose(m_axis_tvalid) |-> ($past(state_q) == S_EXEC
               || $past(state_q) == S_READ || $past(state_q) == S_INSERT),
               "result without a finished command")
  // total waiting bounded by the store size
  `MLPQ_ASSERT_NEVER(a_waiting_bound, 32'(waiting_next) > 32'(NUM_LANES * QUEUE_DEPTH),
                     "waiting count exceeds store capacity")

endmodule

[tb/tb.sv]
// testbench for the multi-lane priority queue unit, directed table and random commands
`timescale 1ns / 100ps

module tb;

  localparam int NUM_LANES   = 4;
  localparam int QUEUE_DEPTH = 64;
  localparam int ID_BITS     = 16;
  localparam int IDLE_PCT    = 18;
  localparam int ITEMS       = 550;

  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_e;

  // one row of the directed table; status and occupancy are typed in where obvious
  typedef struct {
    logic [1:0]  mode;
    logic [2:0]  lane;
    logic [15:0] id;
    bit          urg;
    int          reps;
    bit          rnd_id;
    bit          typed;
    logic [1:0]  t_st;
    logic [6:0]  t_occ;
  } plan_row_t;

  // result owed by the block, with the optional typed-in values
  typedef struct {
    mlpq_pkg::out_item_t res;
    bit                  typed;
    logic [1:0]          t_st;
    logic [6:0]          t_occ;
  } owed_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [mlpq_pkg::LIMIT_W-1:0] cfg_wdata_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [mlpq_pkg::IN_W-1:0]    s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [mlpq_pkg::OUT_W-1:0]   m_axis_tdata;

  // lane state mirror
  logic [16:0]                  lane_slots [NUM_LANES][QUEUE_DEPTH];
  int                           lane_head [NUM_LANES];
  int                           lane_occ [NUM_LANES];
  int                           lane_used [NUM_LANES];
  logic [mlpq_pkg::TOT_W-1:0]   adds_total;
  logic [mlpq_pkg::TOT_W-1:0]   removes_total;
  logic [mlpq_pkg::LIMIT_W-1:0] limit_shadow = mlpq_pkg::MEDIUM_LIMIT_RST;

  owed_t                        results_owed [$];
  int                           errors = 0;
  int                           sent_items = 0;
  bit                           calm = 1'b0;

  plan_row_t plan [25] = '{
    '{mlpq_pkg::MODE_QUERY,  3'd0, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_OK, 7'd0},
    '{mlpq_pkg::MODE_REMOVE, 3'd1, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_EMPTY, 7'd0},
    '{mlpq_pkg::MODE_ADD,    3'd7, 16'hFFFF, 1'b1, 1, 1'b0, 1'b1, mlpq_pkg::ST_BAD_LANE, 7'd0},
    '{mlpq_pkg::MODE_REMOVE, 3'd4, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_BAD_LANE, 7'd0},
    '{mlpq_pkg::MODE_QUERY,  3'd5, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_BAD_LANE, 7'd0},
    '{mlpq_pkg::MODE_ADD,    3'd0, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_OK, 7'd1},
    '{mlpq_pkg::MODE_ADD,    3'd0, 16'hFFFF, 1'b1, 1, 1'b0, 1'b1, mlpq_pkg::ST_OK, 7'd2},
    // a later urgent entry goes ahead of the earlier one
    '{mlpq_pkg::MODE_ADD,    3'd0, 16'h1234, 1'b1, 1, 1'b0, 1'b1, mlpq_pkg::ST_OK, 7'd3},
    '{mlpq_pkg::MODE_ADD,    3'd0, 16'h8000, 1'b0, 1, 1'b0, 1'b0, mlpq_pkg::ST_OK, 7'd0},
    '{mlpq_pkg::MODE_REMOVE, 3'd0, 16'h0000, 1'b0, 4, 1'b0, 1'b0, mlpq_pkg::ST_OK, 7'd0},
    '{mlpq_pkg::MODE_REMOVE, 3'd0, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_EMPTY, 7'd0},
    '{mlpq_pkg::MODE_ADD,    3'd1, 16'h0000, 1'b0, 64, 1'b1, 1'b0, mlpq_pkg::ST_OK, 7'd0},
    '{mlpq_pkg::MODE_ADD,    3'd1, 16'h5A5A, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_FULL, 7'd64},
    '{mlpq_pkg::MODE_REMOVE, 3'd1, 16'h0000, 1'b0, 3, 1'b0, 1'b0, mlpq_pkg::ST_OK, 7'd0},
    // slots are not reused until the lane empties
    '{mlpq_pkg::MODE_ADD,    3'd1, 16'hA5A5, 1'b1, 1, 1'b0, 1'b1, mlpq_pkg::ST_FULL, 7'd61},
    '{mlpq_pkg::MODE_QUERY,  3'd1, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_OK, 7'd61},
    '{mlpq_pkg::MODE_ADD,    3'd2, 16'h0000, 1'b1, 3, 1'b1, 1'b0, mlpq_pkg::ST_OK, 7'd0},
    '{mlpq_pkg::MODE_ADD,    3'd3, 16'h0000, 1'b0, 11, 1'b1, 1'b0, mlpq_pkg::ST_OK, 7'd0},
    '{mlpq_pkg::MODE_QUERY,  3'd3, 16'h0000, 1'b0, 1, 1'b0, 1'b0, mlpq_pkg::ST_OK, 7'd0},
    // clear ignores the lane field
    '{mlpq_pkg::MODE_CLEAR,  3'd6, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_OK, 7'd0},
    '{mlpq_pkg::MODE_QUERY,  3'd1, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_OK, 7'd0},
    '{mlpq_pkg::MODE_REMOVE, 3'd2, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_EMPTY, 7'd0},
    '{mlpq_pkg::MODE_ADD,    3'd3, 16'h0001, 1'b1, 1, 1'b0, 1'b1, mlpq_pkg::ST_OK, 7'd1},
    '{mlpq_pkg::MODE_REMOVE, 3'd3, 16'h0000, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_OK, 7'd0},
    '{mlpq_pkg::MODE_ADD,    3'd3, 16'h0002, 1'b0, 1, 1'b0, 1'b1, mlpq_pkg::ST_OK, 7'd1}
  };

  multi_lane_priority_queue_unit #(
    .NUM_LANES  (NUM_LANES),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // applies one command to the lane mirror and returns the result it owes
  function automatic mlpq_pkg::out_item_t compute_lane_outcome(mlpq_pkg::in_item_t c);
    mlpq_pkg::out_item_t r;
    int                  l;
    int                  wsum;
    logic [16:0]         s;
    r = '0;
    l = int'(c.lane);
    wsum = 0;
    r.status = mlpq_pkg::ST_OK;
    if (c.mode == mlpq_pkg::MODE_CLEAR) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        lane_head[k] = 0;
        lane_occ[k]  = 0;
        lane_used[k] = 0;
      end
      adds_total    = '0;
      removes_total = '0;
    end else if (l >= NUM_LANES) begin
      r.status = mlpq_pkg::ST_BAD_LANE;
    end else if (c.mode == mlpq_pkg::MODE_ADD) begin
      if (lane_used[l] >= QUEUE_DEPTH) begin
        r.status = mlpq_pkg::ST_FULL;
      end else begin
        if (c.urgent) begin
          // entries from the head on move up one slot
          for (int i = lane_used[l]; i > lane_head[l]; i--)
            lane_slots[l][i] = lane_slots[l][i-1];
          lane_slots[l][lane_head[l]] = {1'b1, c.entry_id};
        end else begin
          lane_slots[l][lane_used[l]] = {1'b0, c.entry_id};
        end
        lane_used[l]++;
        lane_occ[l]++;
        if (adds_total != mlpq_pkg::TOT_MAX) adds_total++;
      end
    end else if (c.mode == mlpq_pkg::MODE_REMOVE) begin
      if (lane_occ[l] == 0) begin
        r.status = mlpq_pkg::ST_EMPTY;
      end else begin
        s = lane_slots[l][lane_head[l]];
        r.removed_id     = s[15:0];
        r.removed_urgent = s[16];
        lane_head[l]++;
        lane_occ[l]--;
        if (removes_total != mlpq_pkg::TOT_MAX) removes_total++;
        if (lane_occ[l] == 0) begin
          lane_head[l] = 0;
          lane_used[l] = 0;
        end
      end
    end
    if (c.mode != mlpq_pkg::MODE_CLEAR && l < NUM_LANES) r.lane_occupancy = 7'(lane_occ[l]);
    if (r.lane_occupancy == 0)                 r.density = mlpq_pkg::DENS_LOW;
    else if (r.lane_occupancy <= limit_shadow) r.density = mlpq_pkg::DENS_MEDIUM;
    else                                       r.density = mlpq_pkg::DENS_HIGH;
    for (int k = 0; k < NUM_LANES; k++) wsum += lane_occ[k];
    r.total_added    = adds_total;
    r.total_removed  = removes_total;
    r.total_waiting  = 9'(wsum);
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // drives one command, waits for its transaction and books the owed result
  task automatic send_cmd(input mlpq_pkg::in_item_t c, input bit typed, input logic [1:0] t_st,
                          input logic [6:0] t_occ);
    owed_t w;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    w.res   = compute_lane_outcome(c);
    w.typed = typed;
    w.t_st  = t_st;
    w.t_occ = t_occ;
    results_owed.push_back(w);
    sent_items++;
  endtask

  // stop sending and wait until every owed result is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (results_owed.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [mlpq_pkg::LIMIT_W-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    limit_shadow = v;
    cfg_we_i    <= 1'b0;
  endtask

  // result side: random back-pressure except in the calm phase
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    owed_t               w;
    mlpq_pkg::out_item_t act;
    act = m_axis_tdata;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_owed.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing owed, expected none, actual %0h",
                 $time, act);
      end else begin
        w = results_owed.pop_front();
        check_field("status", 32'(w.res.status), 32'(act.status));
        check_field("removed_id", 32'(w.res.removed_id), 32'(act.removed_id));
        check_field("removed_urgent", 32'(w.res.removed_urgent), 32'(act.removed_urgent));
        check_field("lane_occupancy", 32'(w.res.lane_occupancy), 32'(act.lane_occupancy));
        check_field("density", 32'(w.res.density), 32'(act.density));
        check_field("total_added", w.res.total_added, act.total_added);
        check_field("total_removed", w.res.total_removed, act.total_removed);
        check_field("total_waiting", 32'(w.res.total_waiting), 32'(act.total_waiting));
        if (w.typed) begin
          check_field("table status", 32'(w.t_st), 32'(act.status));
          check_field("table occupancy", 32'(w.t_occ), 32'(act.lane_occupancy));
        end
      end
    end
  end

  initial begin
    mlpq_pkg::in_item_t c;
    phase_e             kind;
    int                 r;
    int                 n;
    int                 focus;
    logic [6:0]         lim;
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_head[k] = 0;
      lane_occ[k]  = 0;
      lane_used[k] = 0;
    end
    adds_total    = '0;
    removes_total = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (plan[i]) begin
      repeat (plan[i].reps) begin
        c          = '0;
        c.mode     = plan[i].mode;
        c.lane     = plan[i].lane;
        c.entry_id = plan[i].rnd_id ? 16'($urandom_range(0, 65535)) : plan[i].id;
        c.urgent   = plan[i].urg;
        send_cmd(c, plan[i].typed, plan[i].t_st, plan[i].t_occ);
      end
    end

    // random phases, each with its own limit and command mix
    for (int ph = 0; sent_items < ITEMS; ph++) begin
      case (ph % 4)
        0, 1:    kind = PH_FILL;
        2:       kind = PH_MIXED;
        default: kind = PH_DRAIN;
      endcase
      case (ph % 6)
        0:       lim = 7'd0;
        1:       lim = 7'd64;
        2:       lim = mlpq_pkg::MEDIUM_LIMIT_RST;
        4:       lim = 7'd1;
        default: lim = 7'($urandom_range(0, 64));
      endcase
      set_limit(lim);
      calm  = (ph == 1);
      focus = $urandom_range(0, NUM_LANES - 1);
      n     = $urandom_range(90, 140);
      for (int j = 0; j < n && sent_items < ITEMS; j++) begin
        c = '0;
        r = $urandom_range(99);
        case (kind)
          PH_FILL:  c.mode = (r < 74) ? mlpq_pkg::MODE_ADD :
                             (r < 86) ? mlpq_pkg::MODE_REMOVE :
                             (r < 99) ? mlpq_pkg::MODE_QUERY : mlpq_pkg::MODE_CLEAR;
          PH_DRAIN: c.mode = (r < 20) ? mlpq_pkg::MODE_ADD :
                             (r < 88) ? mlpq_pkg::MODE_REMOVE :
                             (r < 98) ? mlpq_pkg::MODE_QUERY : mlpq_pkg::MODE_CLEAR;
          default:  c.mode = (r < 45) ? mlpq_pkg::MODE_ADD :
                             (r < 80) ? mlpq_pkg::MODE_REMOVE :
                             (r < 95) ? mlpq_pkg::MODE_QUERY : mlpq_pkg::MODE_CLEAR;
        endcase
        r = $urandom_range(99);
        if (r < 8)       c.lane = 3'($urandom_range(NUM_LANES, 7));
        else if (r < 78) c.lane = 3'(focus);
        else             c.lane = 3'($urandom_range(0, NUM_LANES - 1));
        r = $urandom_range(99);
        if (r < 5)       c.entry_id = 16'h0000;
        else if (r < 10) c.entry_id = 16'hFFFF;
        else             c.entry_id = 16'($urandom_range(0, 65535));
        c.urgent = ($urandom_range(99) < 30);
        send_cmd(c, 1'b0, mlpq_pkg::ST_OK, 7'd0);
        // occasional hold-off until the block has drained
        if ($urandom_range(99) < 2) settle();
      end
    end
    calm = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (results_owed.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
